FILE: design/serial_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// serial_frame_receiver_defines
// Assertion macros shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_DEFINES_SVH

// check a consequence in the same cycle
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check a consequence in the next cycle
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int HDR_BYTES = 5;
  localparam int LEN_W     = 7;   // holds any payload count up to 64

  localparam logic [7:0] CHECK_BASE = 8'hfc;

  localparam logic [7:0]  SYNC_RESET      = 8'hfc;
  localparam logic [7:0]  PRE_FIRST_RESET = 8'h01;
  localparam logic [7:0]  PRE_SECOND_RESET = 8'h30;
  localparam logic [63:0] MASK0_RESET     = 64'd0;
  localparam logic [63:0] MASK1_RESET     = 64'd864691154426265606;
  localparam logic [63:0] MASK2_RESET     = 64'd0;
  localparam logic [63:0] MASK3_RESET     = 64'd0;

  localparam int POS_HUNT = 0;
  localparam int POS_TYPE = 1;
  localparam int POS_PRE1 = 2;
  localparam int POS_PRE2 = 3;
  localparam int POS_LEN  = 4;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TYPE,
    ST_PREAMBLE,
    ST_OVERSIZE,
    ST_CHECKSUM
  } frame_status_t;

  typedef enum logic [2:0] {
    REG_SYNC,
    REG_PRE_FIRST,
    REG_PRE_SECOND,
    REG_MASK0,
    REG_MASK1,
    REG_MASK2,
    REG_MASK3
  } reg_index_t;

  typedef struct packed {
    frame_status_t    status;
    logic [7:0]       kind;
    logic [LEN_W-1:0] len;
    logic             burst;
    logic             bank;
  } frame_cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_free_t;

endpackage

`default_nettype wire

FILE: design/sfr_ram.sv
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Byte parser: hunts sync, checks header, stores payload, checks the sum and
// posts one command per finished frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_frame_receiver_defines.svh"

module sfr_front
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             push,
  output frame_cmd_t       cmd,
  input  wire logic        q_full,
  input  wire bank_free_t  bank_free,
  output logic             ram_we,
  output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] ram_waddr,
  output logic [7:0]       ram_wdata
);

  localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int POS_W  = $clog2(HDR_BYTES + MAX_PAYLOAD + 1);
  localparam int DLEN_W = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]  sync_value;
  logic [7:0]  preamble_first;
  logic [7:0]  preamble_second;
  logic [63:0] type_mask [4];

  logic [POS_W-1:0]  pos, pos_next;
  logic [DLEN_W-1:0] decl, decl_next;
  logic [7:0]        sum, sum_next;
  logic [7:0]        held_type, held_type_next;
  logic              wr_bank, wr_bank_next;
  logic [1:0]        bank_busy, bank_busy_next;

  logic              fire;
  logic [POS_W-1:0]  pay_end;
  logic [POS_W-1:0]  pay_off;
  logic              in_phase;
  logic              type_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value      <= SYNC_RESET;
      preamble_first  <= PRE_FIRST_RESET;
      preamble_second <= PRE_SECOND_RESET;
      type_mask[0]    <= MASK0_RESET;
      type_mask[1]    <= MASK1_RESET;
      type_mask[2]    <= MASK2_RESET;
      type_mask[3]    <= MASK3_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_SYNC:       sync_value      <= cfg_data[7:0];
        REG_PRE_FIRST:  preamble_first  <= cfg_data[7:0];
        REG_PRE_SECOND: preamble_second <= cfg_data[7:0];
        REG_MASK0:      type_mask[0]    <= cfg_data;
        REG_MASK1:      type_mask[1]    <= cfg_data;
        REG_MASK2:      type_mask[2]    <= cfg_data;
        REG_MASK3:      type_mask[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      decl      <= '0;
      sum       <= '0;
      held_type <= '0;
      wr_bank   <= 1'b0;
      bank_busy <= '0;
    end else begin
      pos       <= pos_next;
      decl      <= decl_next;
      sum       <= sum_next;
      held_type <= held_type_next;
      wr_bank   <= wr_bank_next;
      bank_busy <= bank_busy_next;
    end
  end

  assign pay_end  = POS_W'(HDR_BYTES) + POS_W'(decl);
  assign pay_off  = pos - POS_W'(HDR_BYTES);
  assign in_phase = (pos >= POS_W'(HDR_BYTES)) && (pos < pay_end);
  assign in_stall = q_full | (in_phase & bank_busy[wr_bank]);
  assign fire     = in_valid & ~in_stall;
  assign type_ok  = type_mask[rx_byte[7:6]][rx_byte[5:0]];

  always_comb begin
    pos_next       = pos;
    decl_next      = decl;
    sum_next       = sum;
    held_type_next = held_type;
    wr_bank_next   = wr_bank;
    bank_busy_next = bank_busy;
    push           = 1'b0;
    cmd            = '0;
    cmd.kind       = held_type;
    cmd.bank       = wr_bank;
    ram_we         = 1'b0;
    ram_waddr      = {wr_bank, pay_off[IDX_W-1:0]};
    ram_wdata      = rx_byte;

    if (bank_free.valid) begin
      bank_busy_next[bank_free.bank] = 1'b0;
    end

    if (fire) begin
      sum_next = sum + rx_byte;
      pos_next = pos + POS_W'(1);
      case (pos)
        POS_W'(POS_HUNT): begin
          pos_next = '0;
          if (rx_byte == sync_value) begin
            sum_next = rx_byte;
            pos_next = POS_W'(1);
          end
        end
        POS_W'(POS_TYPE): begin
          held_type_next = rx_byte;
          if (!type_ok) begin
            push       = 1'b1;
            cmd.status = ST_TYPE;
            cmd.kind   = rx_byte;
            pos_next   = '0;
          end
        end
        POS_W'(POS_PRE1): begin
          if (rx_byte != preamble_first) begin
            push       = 1'b1;
            cmd.status = ST_PREAMBLE;
            pos_next   = '0;
          end
        end
        POS_W'(POS_PRE2): begin
          if (rx_byte != preamble_second) begin
            push       = 1'b1;
            cmd.status = ST_PREAMBLE;
            pos_next   = '0;
          end
        end
        POS_W'(POS_LEN): begin
          decl_next = DLEN_W'(rx_byte);
          if (rx_byte > 8'(MAX_PAYLOAD)) begin
            decl_next  = decl;
            push       = 1'b1;
            cmd.status = ST_OVERSIZE;
            pos_next   = '0;
          end
        end
        default: begin
          if (in_phase) begin
            ram_we = 1'b1;
          end else begin
            pos_next = '0;
            push     = 1'b1;
            cmd.len  = LEN_W'(decl);
            if (rx_byte != 8'(CHECK_BASE - sum)) begin
              cmd.status = ST_CHECKSUM;
            end else begin
              cmd.status = ST_OK;
              if (decl != '0) begin
                cmd.burst               = 1'b1;
                wr_bank_next            = ~wr_bank;
                bank_busy_next[wr_bank] = 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  `SFR_ASSERT_NOW(a_push_room, push, !q_full, "command posted into a full queue")
  `SFR_ASSERT_NOW(a_write_free_bank, ram_we, !bank_busy[ram_waddr[IDX_W]],
                  "payload written into a bank still being sent")

endmodule

`default_nettype wire

FILE: design/sfr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sfr_cmd_fifo
// Two-entry command queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cmd_fifo
  import sfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire frame_cmd_t cmd_in,
  output logic            full,
  input  wire logic       pop,
  output frame_cmd_t      head,
  output logic            empty
);

  frame_cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head  = entries[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

endmodule

`default_nettype wire

FILE: design/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Result sequencer: turns queued commands into result beats, reading stored
// payload through a registered RAM stage into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_frame_receiver_defines.svh"

module sfr_back
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire frame_cmd_t head,
  input  wire logic       q_empty,
  output logic            pop,
  output bank_free_t      bank_free,
  output logic            ram_re,
  output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] ram_raddr,
  input  wire logic [7:0] ram_rdata,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      frame_status,
  output logic [7:0]      packet_kind,
  output logic [4:0]      payload_length,
  output logic [3:0]      byte_index,
  output logic [7:0]      payload_value,
  output logic            has_byte,
  output logic            last_of_frame
);

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [IDX_W-1:0] idx, idx_next;
  logic             adv;
  logic             issue;
  logic             last_elem;
  logic [LEN_W-1:0] idx_ext;

  logic             s1_valid;
  frame_status_t    s1_status;
  logic [7:0]       s1_kind;
  logic [4:0]       s1_len;
  logic [3:0]       s1_idx;
  logic             s1_has;
  logic             s1_last;

  assign idx_ext   = LEN_W'(idx);
  assign adv       = ~out_valid | ~out_stall;
  assign issue     = adv & ~q_empty;
  assign last_elem = ~head.burst | ((idx_ext + LEN_W'(1)) == head.len);
  assign pop       = issue & last_elem;
  assign ram_re    = issue & head.burst;
  assign ram_raddr = {head.bank, idx};

  always_comb begin
    bank_free.valid = pop & head.burst;
    bank_free.bank  = head.bank;
    idx_next        = idx;
    if (issue) begin
      idx_next = last_elem ? '0 : idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (adv) begin
        s1_valid  <= issue;
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_status      <= head.status;
      s1_kind        <= head.kind;
      s1_len         <= head.len[4:0];
      s1_idx         <= idx_ext[3:0];
      s1_has         <= head.burst;
      s1_last        <= last_elem;
      frame_status   <= s1_status;
      packet_kind    <= s1_kind;
      payload_length <= s1_len;
      byte_index     <= s1_idx;
      payload_value  <= s1_has ? ram_rdata : 8'd0;
      has_byte       <= s1_has;
      last_of_frame  <= s1_last;
    end
  end

  `SFR_ASSERT_NOW(a_read_in_range, issue && head.burst, idx_ext < head.len,
                  "payload read beyond the frame length")
  `SFR_ASSERT_NEXT(a_stage_hold, s1_valid && !adv, s1_valid,
                   "read stage lost a beat while the output was stalled")

endmodule

`default_nettype wire

FILE: design/serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Sync / type / preamble / length / checksum frame parser with payload burst
// output. Parser and result sequencer run apart through a command queue.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall   rx_byte
//   result    out        out_valid / out_stall frame_status .. last_of_frame
//   config    in         cfg_we                cfg_index, cfg_data
//
// One byte is taken each cycle while in_stall is low; the parser holds no multi-cycle work.
// While out_stall is low, a good frame sends one result beat per cycle, set by the single RAM read port.
// in_stall rises while the two-entry command queue is full, or while a payload
// byte would land in the store bank whose burst is still being sent.
// Reset is synchronous; the payload store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       frame_status,
  output logic [7:0]       packet_kind,
  output logic [4:0]       payload_length,
  output logic [3:0]       byte_index,
  output logic [7:0]       payload_value,
  output logic             has_byte,
  output logic             last_of_frame
);

  localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int ADDR_W = IDX_W + 1;

  logic              push;
  frame_cmd_t        cmd;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  frame_cmd_t        head;
  bank_free_t        bank_free;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  sfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .push      (push),
    .cmd       (cmd),
    .q_full    (q_full),
    .bank_free (bank_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  sfr_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd_in (cmd),
    .full   (q_full),
    .pop    (pop),
    .head   (head),
    .empty  (q_empty)
  );

  sfr_ram #(.WIDTH(8), .DEPTH(2 ** ADDR_W)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .bank_free      (bank_free),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_status   (frame_status),
    .packet_kind    (packet_kind),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .payload_value  (payload_value),
    .has_byte       (has_byte),
    .last_of_frame  (last_of_frame)
  );

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for serial_frame_receiver. Feeds sync / type / preamble / length /
// payload / checksum frames, broken headers and stray bytes. A parser model in
// the bench predicts each result beat, and every beat the block sends is
// compared field by field with the oldest prediction. The run covers reset
// and extreme register settings, random idle on the input and stall on the output, and
// a long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
  import sfr_pkg::*;

  localparam int MAX_BYTES = 16;
  localparam int LIMIT_NS = 5_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES = 20000;
  localparam int MAX_REPORTS = 100;

  typedef enum {
    CLEAN,
    BAD_TYPE,
    BAD_PRE_FIRST,
    BAD_PRE_SECOND,
    BAD_LENGTH,
    BAD_SUM
  } frame_flaw_t;

  typedef logic [7:0] octet_q_t [$];

  typedef struct {
    frame_status_t status;
    logic [7:0]    kind;
    logic [4:0]    len;
    logic [3:0]    idx;
    logic [7:0]    value;
    logic          has;
    logic          last;
  } frame_beat_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  frame_status;
  logic [7:0]  packet_kind;
  logic [4:0]  payload_length;
  logic [3:0]  byte_index;
  logic [7:0]  payload_value;
  logic        has_byte;
  logic        last_of_frame;

  // parser model state and its copy of the registers
  logic [7:0]  sync_reg;
  logic [7:0]  pre_first_reg;
  logic [7:0]  pre_second_reg;
  logic [63:0] kind_mask [4];
  int          frame_pos;
  int          decl_len;
  logic [7:0]  byte_sum;
  logic [7:0]  held_kind;
  logic [7:0]  payload_mem [MAX_BYTES];

  frame_beat_t expected_beats [$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;

  serial_frame_receiver #(.MAX_PAYLOAD(MAX_BYTES)) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_status  (frame_status),
    .packet_kind   (packet_kind),
    .payload_length(payload_length),
    .byte_index    (byte_index),
    .payload_value (payload_value),
    .has_byte      (has_byte),
    .last_of_frame (last_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic void reset_parser_model();
    sync_reg = 8'hfc;
    pre_first_reg = 8'h01;
    pre_second_reg = 8'h30;
    kind_mask = '{64'd0, 64'd864691154426265606, 64'd0, 64'd0};
    frame_pos = POS_HUNT;
    decl_len = 0;
    byte_sum = 8'd0;
    held_kind = 8'd0;
    foreach (payload_mem[i]) payload_mem[i] = 8'd0;
  endfunction

  function automatic void push_beat(input frame_status_t st, input logic [7:0] kind,
                                    input logic [4:0] len, input logic [3:0] idx,
                                    input logic [7:0] value, input logic has,
                                    input logic last);
    frame_beat_t bt;
    bt.status = st;
    bt.kind = kind;
    bt.len = len;
    bt.idx = idx;
    bt.value = value;
    bt.has = has;
    bt.last = last;
    expected_beats.push_back(bt);
  endfunction

  function automatic void end_frame(input frame_status_t st, input logic [7:0] kind,
                                    input logic [4:0] len);
    frame_pos = POS_HUNT;
    push_beat(st, kind, len, 4'd0, 8'd0, 1'b0, 1'b1);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [7:0] want_sum;
    int i;
    if (frame_pos == POS_HUNT) begin
      if (b == sync_reg) begin
        byte_sum = b;
        frame_pos = POS_TYPE;
      end
      return;
    end
    if (frame_pos == POS_TYPE) begin
      if (!kind_mask[b[7:6]][b[5:0]]) begin
        end_frame(ST_TYPE, b, 5'd0);
        return;
      end
      held_kind = b;
    end else if (frame_pos == POS_PRE1) begin
      if (b != pre_first_reg) begin
        end_frame(ST_PREAMBLE, held_kind, 5'd0);
        return;
      end
    end else if (frame_pos == POS_PRE2) begin
      if (b != pre_second_reg) begin
        end_frame(ST_PREAMBLE, held_kind, 5'd0);
        return;
      end
    end else if (frame_pos == POS_LEN) begin
      if (b > MAX_BYTES) begin
        end_frame(ST_OVERSIZE, held_kind, 5'd0);
        return;
      end
      decl_len = int'(b);
    end else if (frame_pos < HDR_BYTES + decl_len) begin
      payload_mem[frame_pos - HDR_BYTES] = b;
    end else begin
      frame_pos = POS_HUNT;
      want_sum = CHECK_BASE - byte_sum;
      if (want_sum != b) begin
        end_frame(ST_CHECKSUM, held_kind, decl_len[4:0]);
      end else if (decl_len == 0) begin
        push_beat(ST_OK, held_kind, 5'd0, 4'd0, 8'd0, 1'b0, 1'b1);
      end else begin
        for (i = 0; i < decl_len; i++) begin
          push_beat(ST_OK, held_kind, decl_len[4:0], i[3:0], payload_mem[i], 1'b1,
                    i == decl_len - 1);
        end
      end
      return;
    end
    byte_sum = byte_sum + b;
    frame_pos++;
  endfunction

  always @(posedge clk) begin : check_beats
    frame_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: status %0d kind %0d index %0d",
                                  frame_status, packet_kind, byte_index));
      end else begin
        want = expected_beats.pop_front();
        if (frame_status !== want.status)
          report_mismatch($sformatf("frame_status %0d, want %0d", frame_status, want.status));
        if (packet_kind !== want.kind)
          report_mismatch($sformatf("packet_kind %0d, want %0d", packet_kind, want.kind));
        if (payload_length !== want.len)
          report_mismatch($sformatf("payload_length %0d, want %0d", payload_length, want.len));
        if (byte_index !== want.idx)
          report_mismatch($sformatf("byte_index %0d, want %0d", byte_index, want.idx));
        if (payload_value !== want.value)
          report_mismatch($sformatf("payload_value %0d, want %0d", payload_value, want.value));
        if (has_byte !== want.has)
          report_mismatch($sformatf("has_byte %0d, want %0d", has_byte, want.has));
        if (last_of_frame !== want.last)
          report_mismatch($sformatf("last_of_frame %0d, want %0d", last_of_frame, want.last));
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    if (frame_pos != POS_HUNT || b == sync_reg) bytes_sent++;
    parse_rx_byte(b);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_SYNC:       sync_reg = value[7:0];
      REG_PRE_FIRST:  pre_first_reg = value[7:0];
      REG_PRE_SECOND: pre_second_reg = value[7:0];
      REG_MASK0:      kind_mask[0] = value;
      REG_MASK1:      kind_mask[1] = value;
      REG_MASK2:      kind_mask[2] = value;
      REG_MASK3:      kind_mask[3] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // return the parser to hunting, drop valid, wait out every predicted beat
  task automatic settle();
    int waited;
    while (frame_pos != POS_HUNT) send_byte(8'($urandom_range(0, 255)));
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_beats.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    if (expected_beats.size() != 0) begin
      report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
      expected_beats.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_kind(input bit want_accepted);
    int start;
    int i;
    logic [7:0] t;
    start = $urandom_range(0, 255);
    for (i = 0; i < 256; i++) begin
      t = 8'(start + i);
      if (kind_mask[t[7:6]][t[5:0]] == want_accepted) return int'(t);
    end
    return -1;
  endfunction

  function automatic logic [7:0] wrong_byte(input logic [7:0] right);
    if (sync_reg != right && $urandom_range(0, 3) == 0) return sync_reg;
    return right ^ 8'($urandom_range(1, 255));
  endfunction

  function automatic octet_q_t random_payload(input int n);
    octet_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  function automatic int short_len();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, MAX_BYTES);
    return $urandom_range(0, 4);
  endfunction

  task automatic send_frame(input frame_flaw_t flaw, input octet_q_t payload,
                            input int kind_sel = -1);
    octet_q_t frame_bytes;
    int k;
    int keep;
    logic [7:0] sum;
    k = kind_sel;
    if (k < 0) k = pick_kind(flaw != BAD_TYPE);
    if (k < 0) k = $urandom_range(0, 255);
    frame_bytes = {sync_reg, k[7:0], pre_first_reg, pre_second_reg, 8'(payload.size())};
    foreach (payload[i]) frame_bytes.push_back(payload[i]);
    sum = 8'd0;
    foreach (frame_bytes[i]) sum += frame_bytes[i];
    frame_bytes.push_back(CHECK_BASE - sum);
    keep = frame_bytes.size();
    case (flaw)
      BAD_TYPE: keep = 2;
      BAD_PRE_FIRST: begin
        frame_bytes[2] = wrong_byte(pre_first_reg);
        keep = 3;
      end
      BAD_PRE_SECOND: begin
        frame_bytes[3] = wrong_byte(pre_second_reg);
        keep = 4;
      end
      BAD_LENGTH: begin
        if (sync_reg > MAX_BYTES && $urandom_range(0, 3) == 0) frame_bytes[4] = sync_reg;
        else frame_bytes[4] = 8'($urandom_range(MAX_BYTES + 1, 255));
        keep = 5;
      end
      BAD_SUM: frame_bytes[keep-1] = wrong_byte(frame_bytes[keep-1]);
      default: ;
    endcase
    for (int i = 0; i < keep; i++) send_byte(frame_bytes[i]);
  endtask

  task automatic run_traffic(input int n_bytes);
    int stop_at;
    int r;
    logic [7:0] noise;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        noise = 8'($urandom_range(0, 255));
        if (noise == sync_reg) noise = ~noise;
        send_byte(noise);
      end else if (r < 75) begin
        send_frame(CLEAN, random_payload(short_len()));
      end else begin
        send_frame(frame_flaw_t'($urandom_range(BAD_TYPE, BAD_SUM)),
                   random_payload(short_len()));
      end
    end
    settle();
  endtask

  task automatic test_header_checks();
    octet_q_t none;
    octet_q_t one;
    octet_q_t two;
    one = {8'h5a};
    two = {8'h00, 8'hff};
    idle_pct = 0;
    stall_pct = 0;
    send_byte(~sync_reg);
    // a rejected type byte equal to sync must not restart the frame
    send_frame(BAD_TYPE, none, sync_reg);
    send_frame(BAD_PRE_FIRST, none);
    send_frame(BAD_PRE_SECOND, none);
    send_frame(BAD_LENGTH, none);
    send_frame(BAD_SUM, one);
    send_frame(CLEAN, none);
    send_frame(CLEAN, two);
    settle();
  endtask

  task automatic test_setting_phases();
    idle_pct = 0;
    stall_pct = 0;
    run_traffic(20);

    write_reg(REG_SYNC, 64'h00);
    write_reg(REG_PRE_FIRST, 64'hff);
    write_reg(REG_PRE_SECOND, 64'h00);
    write_reg(REG_MASK0, '1);
    write_reg(REG_MASK1, '1);
    write_reg(REG_MASK2, '1);
    write_reg(REG_MASK3, '1);
    idle_pct = 50;
    run_traffic(20);

    write_reg(REG_SYNC, 64'hff);
    write_reg(REG_PRE_FIRST, 64'h00);
    write_reg(REG_PRE_SECOND, 64'hff);
    write_reg(REG_MASK0, {$urandom, $urandom});
    write_reg(REG_MASK1, {$urandom, $urandom});
    write_reg(REG_MASK2, {$urandom, $urandom});
    write_reg(REG_MASK3, {$urandom, $urandom});
    idle_pct = 0;
    stall_pct = 50;
    run_traffic(20);

    write_reg(REG_SYNC, 64'($urandom_range(0, 255)));
    write_reg(REG_PRE_FIRST, 64'($urandom_range(0, 255)));
    write_reg(REG_PRE_SECOND, 64'($urandom_range(0, 255)));
    write_reg(REG_MASK0, {$urandom, $urandom} | 64'h1);
    write_reg(REG_MASK3, {$urandom, $urandom} | 64'h8000_0000_0000_0000);
    idle_pct = 32;
    stall_pct = 32;
    run_traffic(20);
  endtask

  task automatic test_all_kinds_rejected();
    write_reg(REG_MASK0, 64'd0);
    write_reg(REG_MASK1, 64'd0);
    write_reg(REG_MASK2, 64'd0);
    write_reg(REG_MASK3, 64'd0);
    idle_pct = 0;
    stall_pct = 0;
    repeat (3) send_frame(CLEAN, random_payload(2));
    settle();
  endtask

  task automatic test_output_holdoff();
    write_reg(REG_MASK0, '1);
    write_reg(REG_MASK1, '1);
    write_reg(REG_MASK2, '1);
    write_reg(REG_MASK3, '1);
    idle_pct = 0;
    stall_pct = 0;
    // hold the output long enough that the block backs up into its input
    hold_left = 400;
    repeat (3) send_frame(CLEAN, random_payload(MAX_BYTES));
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 3'd0;
    cfg_data = 64'd0;
    in_valid = 1'b0;
    rx_byte = 8'd0;
    reset_parser_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_header_checks();
    test_setting_phases();
    test_all_kinds_rejected();
    test_output_holdoff();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/sfr_pkg.sv
design/sfr_ram.sv
design/sfr_front.sv
design/sfr_cmd_fifo.sv
design/sfr_back.sv
design/serial_frame_receiver.sv
verif/tb.sv
